// File: hdl/btmx_pkg.sv
// btmx_pkg: shared types and constants for the binary trie maximum-xor block
// transaction payloads and the command/status bundles between controller and datapath
// no dependencies
`timescale 1ns / 1ps

package btmx_pkg;

   localparam int NODE_COUNT_DEF = 4096;
   localparam int KEY_BITS_DEF   = 32;
   localparam int DATA_W         = 32;

   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_QUERY  = 1'b1;

   typedef struct packed {
      logic              kind;
      logic [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] max_xor;
      logic              found;
      logic              store_full;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic rd;
      logic eval;
      logic link;
      logic fill;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic is_query;
      logic miss;
      logic fits;
      logic level_zero;
      logic out_free;
   } stat_type;

endpackage

// File: hdl/btmx_ctrl.sv
// btmx_ctrl: sequencing state machine for the trie walk and node allocation
// depends on btmx_pkg for the command and status bundles
`timescale 1ns / 1ps

module btmx_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  btmx_pkg::stat_type stat,
   output btmx_pkg::cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_LINK,
      ST_FILL,
      ST_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.rd   = 1'b1;
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            if (stat.miss) begin
               if (stat.is_query || !stat.fits) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_LINK;
               end
            end else if (stat.level_zero) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_LINK: begin
            cmd.link = 1'b1;
            state_in = ST_FILL;
         end
         ST_FILL: begin
            cmd.fill = 1'b1;
            if (stat.level_zero) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

// File: hdl/btmx_dp.sv
// btmx_dp: trie datapath with node memory, root links, walk registers and result register
// depends on btmx_pkg for payload, command and status types
`timescale 1ns / 1ps

module btmx_dp #(
   parameter int NODE_COUNT = btmx_pkg::NODE_COUNT_DEF,
   parameter int KEY_BITS   = btmx_pkg::KEY_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  btmx_pkg::req_type  req_data,
   input  logic               rsp_stall,
   output logic               rsp_valid,
   output btmx_pkg::rsp_type  rsp_data,
   input  btmx_pkg::cmd_type  cmd,
   output btmx_pkg::stat_type stat
);

   localparam int IDX_W  = $clog2(NODE_COUNT);
   localparam int CNT_W  = $clog2(NODE_COUNT + 1);
   localparam int LVL_W  = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
   localparam int NEED_W = $clog2(KEY_BITS + 1);
   localparam int ENT_W  = 2 * IDX_W;

   logic [ENT_W-1:0] mem [NODE_COUNT];
   logic [ENT_W-1:0] rd_ff;

   logic                kind_ff;
   logic [KEY_BITS-1:0] key_ff;
   logic [IDX_W-1:0]    cur_ff;
   logic [LVL_W-1:0]    level_ff;
   logic [KEY_BITS-1:0] acc_ff;
   logic [CNT_W-1:0]    used_ff;
   logic [IDX_W-1:0]    root0_ff;
   logic [IDX_W-1:0]    root1_ff;
   logic                found_ff;
   logic                full_ff;
   logic                rsp_valid_ff;
   btmx_pkg::rsp_type   rsp_data_ff;

   logic [ENT_W-1:0]  links;
   logic              bit_cur;
   logic [IDX_W-1:0]  link_same;
   logic [IDX_W-1:0]  link_opp;
   logic [IDX_W-1:0]  nxt;
   logic              miss;
   logic              take_opp;
   logic [NEED_W-1:0] needed;
   logic              fits;
   logic              level_zero;
   logic [IDX_W-1:0]  fresh;
   logic [LVL_W-1:0]  level_dn;
   logic [ENT_W-1:0]  link_wdata;
   logic [ENT_W-1:0]  fill_wdata;

   // links of the current node: the root sits in flops
   assign links      = (cur_ff == '0) ? {root1_ff, root0_ff} : rd_ff;
   assign bit_cur    = key_ff[level_ff];
   assign link_same  = bit_cur ? links[ENT_W-1:IDX_W] : links[IDX_W-1:0];
   assign link_opp   = bit_cur ? links[IDX_W-1:0] : links[ENT_W-1:IDX_W];
   assign take_opp   = (kind_ff == btmx_pkg::KIND_QUERY) && (link_opp != '0);
   assign nxt        = take_opp ? link_opp : link_same;
   assign miss       = (nxt == '0);
   assign level_zero = (level_ff == '0);
   assign level_dn   = LVL_W'(level_ff - 1'b1);
   assign needed     = NEED_W'(level_ff) + NEED_W'(1);
   assign fits       = (CNT_W'(needed) <= (CNT_W'(NODE_COUNT) - used_ff));
   assign fresh      = used_ff[IDX_W-1:0];

   always_comb begin
      link_wdata = links;
      if (bit_cur) begin
         link_wdata[ENT_W-1:IDX_W] = fresh;
      end else begin
         link_wdata[IDX_W-1:0] = fresh;
      end
      fill_wdata = '0;
      if (!level_zero) begin
         if (key_ff[level_dn]) begin
            fill_wdata[ENT_W-1:IDX_W] = IDX_W'(fresh + 1'b1);
         end else begin
            fill_wdata[IDX_W-1:0] = IDX_W'(fresh + 1'b1);
         end
      end
   end

   // node memory
   always_ff @(posedge clock) begin
      if (cmd.link && (cur_ff != '0)) begin
         mem[cur_ff] <= link_wdata;
      end else if (cmd.fill) begin
         mem[fresh] <= fill_wdata;
      end
      if (cmd.rd) begin
         rd_ff <= mem[cur_ff];
      end
   end

   // walk registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff  <= req_data.kind;
         key_ff   <= req_data.value[KEY_BITS-1:0];
         cur_ff   <= '0;
         level_ff <= LVL_W'(KEY_BITS - 1);
         acc_ff   <= '0;
         found_ff <= 1'b0;
         full_ff  <= 1'b0;
      end else if (cmd.eval) begin
         if (!miss) begin
            cur_ff <= nxt;
            if (take_opp) begin
               acc_ff[level_ff] <= 1'b1;
            end
            if (level_zero) begin
               found_ff <= (kind_ff == btmx_pkg::KIND_QUERY);
            end else begin
               level_ff <= level_dn;
            end
         end else if ((kind_ff == btmx_pkg::KIND_INSERT) && !fits) begin
            full_ff <= 1'b1;
         end
      end else if (cmd.fill && !level_zero) begin
         level_ff <= level_dn;
      end
   end

   // root links and allocation count
   always_ff @(posedge clock) begin
      if (reset) begin
         root0_ff <= '0;
         root1_ff <= '0;
         used_ff  <= CNT_W'(1);
      end else begin
         if (cmd.link && (cur_ff == '0)) begin
            root0_ff <= link_wdata[IDX_W-1:0];
            root1_ff <= link_wdata[ENT_W-1:IDX_W];
         end
         if (cmd.fill) begin
            used_ff <= CNT_W'(used_ff + 1'b1);
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_data_ff.max_xor    <= found_ff ? btmx_pkg::DATA_W'(acc_ff) : '0;
         rsp_data_ff.found      <= found_ff;
         rsp_data_ff.store_full <= full_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign stat.is_query   = (kind_ff == btmx_pkg::KIND_QUERY);
   assign stat.miss       = miss;
   assign stat.fits       = fits;
   assign stat.level_zero = level_zero;
   assign stat.out_free   = !rsp_valid_ff || !rsp_stall;

endmodule

// File: hdl/binary_trie_max_xor.sv
// Binary trie maximum-xor block: insert keys into a trie held in a node memory and
// answer maximum-xor queries against the stored keys. One transaction is in work at a
// time; a new request is taken as soon as the previous result sits in the output
// register. Each trie level takes a node-memory read, then the decision. An insert
// walks the existing path the same way and then writes one node per cycle for the new
// part of the path. The root links live in flops cleared by reset; other nodes are
// written as they are allocated, so there is no clearing pass after reset.
// depends on btmx_pkg, btmx_ctrl and btmx_dp
`timescale 1ns / 1ps

module binary_trie_max_xor #(
   parameter int NODE_COUNT = btmx_pkg::NODE_COUNT_DEF,
   parameter int KEY_BITS   = btmx_pkg::KEY_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  btmx_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output btmx_pkg::rsp_type rsp_data
);

   btmx_pkg::cmd_type  cmd;
   btmx_pkg::stat_type stat;

   btmx_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   btmx_dp #(
      .NODE_COUNT (NODE_COUNT),
      .KEY_BITS   (KEY_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule
